// ===== design/owrse_pkg.sv =====
// owrse_pkg: codes, widths and constants of the 1-Wire ROM search engine.
// No dependencies; imported by onewire_rom_search_engine.
`timescale 1ns / 1ps
`default_nettype none

package owrse_pkg;

   // Field and state widths
   localparam int unsigned KindW   = 2;
   localparam int unsigned ActionW = 3;
   localparam int unsigned StatusW = 3;
   localparam int unsigned ByteW   = 8;
   localparam int unsigned RomW    = 64;
   localparam int unsigned PosW    = 7;
   localparam int unsigned FamW    = 4;
   localparam int unsigned IdxW    = 6;
   localparam int unsigned CsrIdxW = 1;

   typedef logic [KindW-1:0]   kind_type;
   typedef logic [ActionW-1:0] action_type;
   typedef logic [StatusW-1:0] status_type;
   typedef logic [PosW-1:0]    pos_type;

   // Input word kinds
   localparam kind_type KIND_CLEAR = 2'd0;
   localparam kind_type KIND_START = 2'd1;
   localparam kind_type KIND_BITS  = 2'd2;

   // Result actions
   localparam action_type ACT_NONE         = 3'd0;
   localparam action_type ACT_SEND_CMD     = 3'd1;
   localparam action_type ACT_WRITE_BIT    = 3'd2;
   localparam action_type ACT_WRITE_FINISH = 3'd3;
   localparam action_type ACT_FINISH       = 3'd4;

   // Pass status
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_NO_PRESENCE = 3'd1;
   localparam status_type ST_DONE        = 3'd2;
   localparam status_type ST_NO_RESPONSE = 3'd3;
   localparam status_type ST_CRC_BAD     = 3'd4;
   localparam status_type ST_ZERO_FAMILY = 3'd5;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_SEARCH_CMD = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_ALARM_CMD  = 1'd1;

   localparam logic [ByteW-1:0] SEARCH_CMD_RESET = 8'hF0;
   localparam logic [ByteW-1:0] ALARM_CMD_RESET  = 8'hEC;

   // Search constants
   localparam logic [ByteW-1:0] CRC_POLY     = 8'h8C;
   localparam pos_type          FIRST_BIT    = 7'd1;
   localparam pos_type          LAST_BIT     = 7'd64;
   localparam pos_type          PAST_LAST    = 7'd65;
   localparam pos_type          FAMILY_LIMIT = 7'd9;

endpackage : owrse_pkg

`default_nettype wire

// ===== design/onewire_rom_search_engine.sv =====
// onewire_rom_search_engine: 1-Wire ROM search (normal / alarm) decision logic.
// Depends on owrse_pkg for codes and constants.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports                      | direction | moves
//  ---------+----------------------------+-----------+------------------------------
//  req      | req_valid/req_stall/req_*  | in        | one command or bit-pair word
//  rsp      | rsp_valid/rsp_stall/rsp_*  | out       | one result word per req word
//  csr      | csr_write_enable/index/data| in        | search and alarm command bytes
//
//  Every req word is decided in the cycle it is accepted; its result word sits in
//  the rsp output register on the next cycle. One word per cycle when not
//  stalled, set by the single output register. req_stall is high only while a
//  held result is stalled. Reset (synchronous, active high) clears the search
//  state, sets bit position to one and loads the default command bytes 0xF0 / 0xEC.

module onewire_rom_search_engine
   import owrse_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [KindW-1:0]   req_kind,
   input  wire logic               req_alarm_mode,
   input  wire logic               req_presence,
   input  wire logic               req_id_bit,
   input  wire logic               req_complement_bit,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [ActionW-1:0]      rsp_action,
   output logic [ByteW-1:0]        rsp_command_byte,
   output logic                    rsp_direction,
   output logic                    rsp_found,
   output logic                    rsp_last_device,
   output logic [RomW-1:0]         rsp_rom_id,
   output logic [FamW-1:0]         rsp_family_discrepancy,
   output logic [StatusW-1:0]      rsp_status,
   // configuration port
   input  wire logic               csr_write_enable,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [ByteW-1:0]   csr_write_data
);

   // Search state
   logic [RomW-1:0]  rom_ff, rom_in;
   pos_type          last_disc_ff, last_disc_in;
   logic [FamW-1:0]  fam_disc_ff, fam_disc_in;
   logic             last_dev_ff, last_dev_in;
   pos_type          bit_pos_ff, bit_pos_in;
   pos_type          last_zero_ff, last_zero_in;
   logic [ByteW-1:0] crc_ff, crc_in;
   logic             pass_ff, pass_in;

   // Command bytes
   logic [ByteW-1:0] search_cmd_ff, alarm_cmd_ff;

   // Result register
   logic             rsp_valid_ff;
   action_type       rsp_action_ff, action_in;
   logic [ByteW-1:0] rsp_cmd_ff, cmd_in;
   logic             rsp_dir_ff, dir_in;
   logic             rsp_found_ff, found_in;
   logic             rsp_last_dev_ff;
   logic [RomW-1:0]  rsp_rom_ff;
   logic [FamW-1:0]  rsp_fam_ff;
   status_type       rsp_status_ff, status_in;

   logic             clear_search;
   logic             req_accept;
   logic [IdxW-1:0]  bit_idx;
   logic             crc_mix;

   // Result register frees up when its word leaves in the same cycle.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // ROM bit index is position minus one, modulo 64.
   assign bit_idx = bit_pos_ff[IdxW-1:0] - IdxW'(1);

   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      bit_pos_in   = bit_pos_ff;
      last_zero_in = last_zero_ff;
      crc_in       = crc_ff;
      pass_in      = pass_ff;
      action_in    = ACT_NONE;
      cmd_in       = '0;
      dir_in       = 1'b0;
      found_in     = 1'b0;
      status_in    = ST_OK;
      clear_search = 1'b0;
      crc_mix      = 1'b0;

      case (req_kind)
         KIND_CLEAR: begin
            clear_search = 1'b1;
            pass_in      = 1'b0;
         end
         KIND_START: begin
            if (last_dev_ff) begin
               pass_in   = 1'b0;
               action_in = ACT_FINISH;
               status_in = ST_DONE;
            end else if (!req_presence) begin
               clear_search = 1'b1;
               pass_in      = 1'b0;
               action_in    = ACT_FINISH;
               status_in    = ST_NO_PRESENCE;
            end else begin
               pass_in      = 1'b1;
               bit_pos_in   = FIRST_BIT;
               last_zero_in = '0;
               crc_in       = '0;
               action_in    = ACT_SEND_CMD;
               cmd_in       = req_alarm_mode ? alarm_cmd_ff : search_cmd_ff;
            end
         end
         KIND_BITS: begin
            if (pass_ff) begin
               if (req_id_bit && req_complement_bit) begin
                  // nobody on the bus drove the slot
                  clear_search = 1'b1;
                  pass_in      = 1'b0;
                  action_in    = ACT_FINISH;
                  status_in    = ST_NO_RESPONSE;
               end else begin
                  if (req_id_bit != req_complement_bit) begin
                     dir_in = req_id_bit;
                  end else begin
                     // discrepancy: follow the previous path, take 1 at the
                     // last branch point, 0 beyond it
                     if (bit_pos_ff < last_disc_ff) begin
                        dir_in = rom_ff[bit_idx];
                     end else begin
                        dir_in = (bit_pos_ff == last_disc_ff);
                     end
                     if (!dir_in) begin
                        last_zero_in = bit_pos_ff;
                        if (bit_pos_ff < FAMILY_LIMIT) begin
                           fam_disc_in = bit_pos_ff[FamW-1:0];
                        end
                     end
                  end

                  rom_in[bit_idx] = dir_in;
                  crc_mix = crc_ff[0] ^ dir_in;
                  crc_in  = {1'b0, crc_ff[ByteW-1:1]} ^ (crc_mix ? CRC_POLY : '0);

                  if (bit_pos_ff < LAST_BIT) begin
                     bit_pos_in = bit_pos_ff + FIRST_BIT;
                     action_in  = ACT_WRITE_BIT;
                  end else begin
                     pass_in    = 1'b0;
                     bit_pos_in = PAST_LAST;
                     action_in  = ACT_WRITE_FINISH;
                     if (crc_in != '0) begin
                        clear_search = 1'b1;
                        status_in    = ST_CRC_BAD;
                     end else begin
                        last_disc_in = last_zero_in;
                        if (last_zero_in == '0) begin
                           last_dev_in = 1'b1;
                        end
                        if (rom_in[ByteW-1:0] == '0) begin
                           clear_search = 1'b1;
                           status_in    = ST_ZERO_FAMILY;
                        end else begin
                           found_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (clear_search) begin
         rom_in       = '0;
         last_disc_in = '0;
         fam_disc_in  = '0;
         last_dev_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff        <= '0;
         last_disc_ff  <= '0;
         fam_disc_ff   <= '0;
         last_dev_ff   <= 1'b0;
         bit_pos_ff    <= FIRST_BIT;
         last_zero_ff  <= '0;
         crc_ff        <= '0;
         pass_ff       <= 1'b0;
         search_cmd_ff <= SEARCH_CMD_RESET;
         alarm_cmd_ff  <= ALARM_CMD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SEARCH_CMD: search_cmd_ff <= csr_write_data;
               CSR_ALARM_CMD:  alarm_cmd_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            rom_ff       <= rom_in;
            last_disc_ff <= last_disc_in;
            fam_disc_ff  <= fam_disc_in;
            last_dev_ff  <= last_dev_in;
            bit_pos_ff   <= bit_pos_in;
            last_zero_ff <= last_zero_in;
            crc_ff       <= crc_in;
            pass_ff      <= pass_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded on accept only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_action_ff   <= action_in;
         rsp_cmd_ff      <= cmd_in;
         rsp_dir_ff      <= dir_in;
         rsp_found_ff    <= found_in;
         rsp_last_dev_ff <= last_dev_in;
         rsp_rom_ff      <= rom_in;
         rsp_fam_ff      <= fam_disc_in;
         rsp_status_ff   <= status_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_action             = rsp_action_ff;
   assign rsp_command_byte       = rsp_cmd_ff;
   assign rsp_direction          = rsp_dir_ff;
   assign rsp_found              = rsp_found_ff;
   assign rsp_last_device        = rsp_last_dev_ff;
   assign rsp_rom_id             = rsp_rom_ff;
   assign rsp_family_discrepancy = rsp_fam_ff;
   assign rsp_status             = rsp_status_ff;

   // An open pass always points at one of the 64 ROM bits.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pass_ff |-> (bit_pos_ff >= FIRST_BIT && bit_pos_ff <= LAST_BIT))
      else $error("open pass with bit position out of range");

   // Family discrepancy never leaves the family byte.
   a_fam_range: assert property (@(posedge clock) disable iff (reset)
      fam_disc_ff < FAMILY_LIMIT[FamW-1:0])
      else $error("family discrepancy beyond family byte");

   // Once the last device is found no pass stays open.
   a_last_dev_closed: assert property (@(posedge clock) disable iff (reset)
      last_dev_ff |-> !pass_ff)
      else $error("pass open after last device");

   // Found only comes with a clean final bit.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
         (rsp_action_ff == ACT_WRITE_FINISH && rsp_status_ff == ST_OK))
      else $error("found without a clean finish");

   // A held result word is not overwritten.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_rom_ff) && $stable(rsp_action_ff))
      else $error("stalled result changed");

endmodule : onewire_rom_search_engine

`default_nettype wire
